>>> src/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg
// Shared types and constants for the premultiplied alpha gamma corrector.
// ----------------------------------------------------------------------------
package agc_pkg;

  // pixel layout: alpha in the top byte, then three colour bytes
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned ALPHA_LSB   = 24;
  localparam int unsigned NUM_COLOURS = 3;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  // gamma table: corrected alpha above an unsigned fixed point ratio
  localparam int unsigned RATIO_W     = 24;
  localparam int unsigned ENTRY_W     = BYTE_W + RATIO_W;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);

  // product of one colour byte and a ratio
  localparam int unsigned PROD_W      = BYTE_W + RATIO_W;

  // request kinds
  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

endpackage

>>> src/agc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_in_if / agc_out_if
// Valid/ready channels carrying table loads, pixels and corrected pixels.
// ----------------------------------------------------------------------------
interface agc_in_if;
  import agc_pkg::*;

  logic                valid;
  logic                ready;
  action_e             action;
  logic [BYTE_W-1:0]   entry_index;
  logic [BYTE_W-1:0]   entry_alpha;
  logic [RATIO_W-1:0]  entry_ratio;
  logic [PIXEL_W-1:0]  pixel_in;

  modport source (
    output valid, action, entry_index, entry_alpha, entry_ratio, pixel_in,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, entry_alpha, entry_ratio, pixel_in,
    output ready
  );
endinterface

interface agc_out_if;
  import agc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;

  modport source (
    output valid, pixel_out,
    input  ready
  );

  modport sink (
    input  valid, pixel_out,
    output ready
  );
endinterface

>>> src/alpha_gamma_correct_premultiplied.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_gamma_correct_premultiplied
// Gamma-corrects the alpha of premultiplied pixels and rescales the colours.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes two kinds of request. A load request writes the corrected
//   alpha and ratio for one alpha value into the 256-entry gamma table and
//   gives no response. A pixel request looks up its alpha in the table and
//   returns one corrected pixel on rsp_o, in request order.
//   A pixel passes through the table read, per-colour multiply and
//   output register stages before it shows on rsp_o.
//   Throughput: one request per cycle unless the receiver stalls, set by
//   the single table read port and the three colour lanes working side
//   by side on each pixel.
//   A pixel may follow a load of its own entry in the very next cycle.
//   Reset clears the pipeline valids only; the table is undefined until
//   software loads it, and there is no clearing pass.
//   When the receiver stalls with a response waiting, the whole pipeline
//   holds and req_i.ready drops until the response is taken.
//   RATIO_FRAC_BITS sets the fixed point position of the loaded ratios.
// ----------------------------------------------------------------------------
module alpha_gamma_correct_premultiplied #(
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  agc_in_if.sink      req_i,
  agc_out_if.source   rsp_o
);
  import agc_pkg::*;

  logic                adv;
  logic                req_fire;
  logic                tbl_we;
  logic [ENTRY_W-1:0]  tbl_rdata;

  logic                s1_vld_q;
  logic [BYTE_W*NUM_COLOURS-1:0] s1_colour_q;

  logic                s2_vld_q;
  logic [BYTE_W-1:0]   s2_alpha_q;
  logic [BYTE_W-1:0]   lane_colour [NUM_COLOURS];

  logic                out_vld_q;
  logic [PIXEL_W-1:0]  out_pixel_q;
  logic [PIXEL_W-1:0]  out_pixel_d;

  // pipeline moves whenever the output register is free or being drained
  assign adv       = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign req_fire  = req_i.valid && adv;
  assign tbl_we    = req_fire && (req_i.action == ACT_LOAD);

  // gamma table
  agc_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (req_i.entry_index),
    .wdata_i ({req_i.entry_alpha, req_i.entry_ratio}),
    .re_i    (adv),
    .raddr_i (req_i.pixel_in[PIXEL_W-1:ALPHA_LSB]),
    .rdata_o (tbl_rdata)
  );

  // stage 1: table read in flight, colours carried alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= req_fire && (req_i.action == ACT_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_colour_q <= req_i.pixel_in[ALPHA_LSB-1:0];
    end
  end

  // stage 2: colour lanes multiply, corrected alpha carried alongside
  for (genvar i = 0; i < NUM_COLOURS; i++) begin : g_lane
    agc_lane #(
      .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .colour_i (s1_colour_q[i*BYTE_W +: BYTE_W]),
      .ratio_i  (tbl_rdata[RATIO_W-1:0]),
      .colour_o (lane_colour[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_alpha_q <= tbl_rdata[ENTRY_W-1:RATIO_W];
    end
  end

  // merge: corrected alpha over the three clamped colours
  assign out_pixel_d = {s2_alpha_q, lane_colour[2], lane_colour[1], lane_colour[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pixel_q <= out_pixel_d;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.pixel_out = out_pixel_q;

  // a pixel request enters the pipeline
  a_pixel_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.action == ACT_PIXEL) |=> s1_vld_q)
    else $error("accepted pixel did not enter stage 1");

  // a load request never produces a response slot
  a_load_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.action == ACT_LOAD) |=> !s1_vld_q)
    else $error("load request created a pixel slot");

  // stage 1 advances into stage 2
  a_s1_to_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && adv) |=> s2_vld_q)
    else $error("pixel lost between stage 1 and stage 2");

  // output alpha is the looked-up corrected alpha
  a_alpha_merge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && adv) |=> (out_vld_q &&
      out_pixel_q[PIXEL_W-1:ALPHA_LSB] == $past(s2_alpha_q)))
    else $error("merged alpha does not match stage 2 alpha");

endmodule

>>> src/agc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_table
// Gamma table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module agc_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [agc_pkg::TABLE_AW-1:0]  waddr_i,
  input  logic [agc_pkg::ENTRY_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [agc_pkg::TABLE_AW-1:0]  raddr_i,
  output logic [agc_pkg::ENTRY_W-1:0]   rdata_o
);
  import agc_pkg::*;

  logic [ENTRY_W-1:0] mem_q [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // write port, contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/agc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_lane
// One colour lane: registered byte-by-ratio product, then shift and clamp.
// ----------------------------------------------------------------------------
module agc_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [agc_pkg::BYTE_W-1:0]    colour_i,
  input  logic [agc_pkg::RATIO_W-1:0]   ratio_i,
  output logic [agc_pkg::BYTE_W-1:0]    colour_o
);
  import agc_pkg::*;

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0] scaled;
  logic              sat;

  // byte times ratio
  assign prod_d = PROD_W'(colour_i) * PROD_W'(ratio_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // drop the fraction and clamp to a byte
  assign scaled   = prod_q >> FRAC_BITS;
  assign sat      = |scaled[PROD_W-1:BYTE_W];
  assign colour_o = sat ? BYTE_MAX : scaled[BYTE_W-1:0];

endmodule
